[src/beq_pkg.sv]
// Shared types and constants for the biquad equalizer cascade.
// No dependencies; imported by every module of the block.
package beq_pkg;

    localparam int NUM_BANDS      = 4;
    localparam int COEF_FRAC_BITS = 16;

    localparam int SAMPLE_W   = 16;
    localparam int DATA_W     = 24;   // internal sample, 8 fraction bits
    localparam int DATA_FRAC  = 8;
    localparam int COEF_W     = 21;
    localparam int PROD_W     = COEF_W + DATA_W;
    localparam int ACC_W      = PROD_W + 3;   // five terms
    localparam int FWD_W      = 3 * COEF_W;
    localparam int BWD_W      = 2 * COEF_W;
    localparam int CFG_W      = FWD_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [FWD_W-1:0] FWD_RESET = FWD_W'(65536);
    localparam logic [BWD_W-1:0] BWD_RESET = '0;

    // One sample moving between neighboring sections
    typedef struct packed {
        logic              valid;
        logic              start;
        logic [DATA_W-1:0] data;
    } t_cell_link;

    // Coefficient write routed to one section
    typedef struct packed {
        logic             we_fwd;
        logic             we_bwd;
        logic [CFG_W-1:0] data;
    } t_cfg_wr;

    function automatic logic signed [COEF_W-1:0] coef_at(input logic [FWD_W-1:0] word,
                                                         input int unsigned pos);
        coef_at = $signed(word[pos +: COEF_W]);
    endfunction

endpackage

[src/beq_in_if.sv]
// Input channel: one audio sample and its start-of-buffer flag.
// Uses beq_pkg for field widths.
interface beq_in_if import beq_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       buffer_start;

    modport source (output valid, output sample_in, output buffer_start, input ready);
    modport sink   (input valid, input sample_in, input buffer_start, output ready);
endinterface

[src/beq_out_if.sv]
// Output channel: one filtered audio sample.
// Uses beq_pkg for field widths.
interface beq_out_if import beq_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

[src/beq_cell.sv]
// One direct-form-1 biquad section: coefficients, history and a shared MAC.
// Depends on beq_pkg.
module beq_cell import beq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg_wr    i_cfg,
    input  t_cell_link i_link,
    output t_cell_link o_link
);

    localparam logic [2:0] PH_B0   = 3'd0;
    localparam logic [2:0] PH_B1   = 3'd1;
    localparam logic [2:0] PH_B2   = 3'd2;
    localparam logic [2:0] PH_A1   = 3'd3;
    localparam logic [2:0] PH_A2   = 3'd4;
    localparam logic [2:0] PH_LAST = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(8388608);

    logic [FWD_W-1:0]         r_fwd;
    logic [BWD_W-1:0]         r_bwd;
    logic signed [DATA_W-1:0] r_ih0, r_ih1, r_oh0, r_oh1;
    logic                     r_busy;
    logic [2:0]               r_phase;
    logic signed [DATA_W-1:0] r_x;
    logic                     r_clr;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    t_cell_link               r_out;

    logic signed [COEF_W-1:0] w_coef;
    logic signed [DATA_W-1:0] w_data;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  w_shift;
    logic signed [DATA_W-1:0] w_y;

    // Operand select for the single multiplier
    always_comb begin
        unique case (r_phase)
            PH_B0: begin
                w_coef = coef_at(r_fwd, 0);
                w_data = r_x;
            end
            PH_B1: begin
                w_coef = coef_at(r_fwd, COEF_W);
                w_data = r_clr ? '0 : r_ih0;
            end
            PH_B2: begin
                w_coef = coef_at(r_fwd, 2 * COEF_W);
                w_data = r_clr ? '0 : r_ih1;
            end
            PH_A1: begin
                w_coef = coef_at(FWD_W'(r_bwd), 0);
                w_data = r_clr ? '0 : r_oh0;
            end
            PH_A2: begin
                w_coef = coef_at(FWD_W'(r_bwd), COEF_W);
                w_data = r_clr ? '0 : r_oh1;
            end
            default: begin
                w_coef = '0;
                w_data = '0;
            end
        endcase
    end

    assign n_prod = w_coef * w_data;
    assign w_term = ACC_W'(r_prod);

    // Product of the previous phase enters the sum; feedback terms subtract
    always_comb begin
        n_acc = r_acc;
        if (r_phase >= PH_B1 && r_phase <= PH_LAST) begin
            if (r_phase >= PH_A2) n_acc = r_acc - w_term;
            else                  n_acc = r_acc + w_term;
        end
    end

    assign w_shift = r_acc >>> COEF_FRAC_BITS;

    always_comb begin
        priority if (w_shift > SAT_HI) w_y = SAT_HI[DATA_W-1:0];
        else if (w_shift < SAT_LO)     w_y = SAT_LO[DATA_W-1:0];
        else                           w_y = w_shift[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd   <= FWD_RESET;
            r_bwd   <= BWD_RESET;
            r_ih0   <= '0;
            r_ih1   <= '0;
            r_oh0   <= '0;
            r_oh1   <= '0;
            r_busy  <= 1'b0;
            r_phase <= PH_B0;
            r_out   <= '0;
        end else begin
            if (i_cfg.we_fwd) r_fwd <= i_cfg.data[FWD_W-1:0];
            if (i_cfg.we_bwd) r_bwd <= i_cfg.data[BWD_W-1:0];

            r_out.valid <= r_busy && (r_phase == PH_DONE);
            if (!r_busy) begin
                if (i_link.valid) begin
                    r_busy  <= 1'b1;
                    r_phase <= PH_B0;
                    r_x     <= $signed(i_link.data);
                    r_clr   <= i_link.start;
                    r_acc   <= '0;
                end
            end else begin
                r_prod <= n_prod;
                r_acc  <= n_acc;
                if (r_phase == PH_DONE) begin
                    r_busy      <= 1'b0;
                    r_out.start <= r_clr;
                    r_out.data  <= w_y;
                    r_ih1       <= r_clr ? '0 : r_ih0;
                    r_ih0       <= r_x;
                    r_oh1       <= r_clr ? '0 : r_oh0;
                    r_oh0       <= w_y;
                end else begin
                    r_phase <= r_phase + 3'd1;
                end
            end
        end
    end

    assign o_link = r_out;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_link.valid)
        else $error("sample arrived while section busy");

    a_out_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid |=> !r_out.valid)
        else $error("section output held for more than one cycle");

    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out.valid) |-> $past(r_busy) && !r_busy)
        else $error("section output without finished computation");

endmodule

[src/biquad_equalizer_cascade_top.sv]
// Top level of the biquad equalizer cascade: config decode, section chain, output stage.
// Depends on beq_pkg, beq_in_if, beq_out_if and beq_cell.
//
//  Channel   Dir  Handshake        Payload
//  i_in      in   valid/ready      sample_in[15:0] signed, buffer_start
//  o_out     out  valid/ready      sample_out[15:0] signed
//  i_cfg_*   in   write enable     i_cfg_index[2:0], i_cfg_data[62:0]
//
// Each section takes a sample through take-over, five multiply steps on its one
// multiplier, a last accumulate, then shift and saturate; the result then passes
// through the result register into the output register.
// One sample is in the chain at a time; the next is accepted once the
// previous result has moved into the output register, even if it waits there.
// Synchronous active-low reset loads identity coefficients and clears history.
module biquad_equalizer_cascade_top import beq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    beq_in_if.sink               i_in,
    beq_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cell_link w_link [NUM_BANDS+1];
    t_cfg_wr    w_cfg  [NUM_BANDS];

    logic                       r_busy;
    logic                       r_res_vld;
    logic signed [SAMPLE_W-1:0] r_res;
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic                       w_accept;
    logic                       w_move;
    logic signed [DATA_W-1:0]   w_last;
    logic signed [DATA_W-1:0]   w_biased;

    assign i_in.ready = !r_busy;
    assign w_accept   = i_in.valid && !r_busy;

    always_comb begin
        w_link[0].valid = w_accept;
        w_link[0].start = i_in.buffer_start;
        w_link[0].data  = {i_in.sample_in, {DATA_FRAC{1'b0}}};
    end

    for (genvar k = 0; k < NUM_BANDS; k++) begin : g_band
        always_comb begin
            w_cfg[k].we_fwd = i_cfg_we && (i_cfg_index[2:1] == 2'(k)) && !i_cfg_index[0];
            w_cfg[k].we_bwd = i_cfg_we && (i_cfg_index[2:1] == 2'(k)) && i_cfg_index[0];
            w_cfg[k].data   = i_cfg_data;
        end

        beq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (w_cfg[k]),
            .i_link  (w_link[k]),
            .o_link  (w_link[k+1])
        );
    end

    // Truncate toward zero: negative values get the fraction mask added first
    assign w_last   = $signed(w_link[NUM_BANDS].data);
    assign w_biased = w_last + (w_last[DATA_W-1] ? DATA_W'((1 << DATA_FRAC) - 1) : '0);

    assign w_move = r_res_vld && (!r_out_vld || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_res_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) r_busy <= 1'b1;
            if (w_link[NUM_BANDS].valid) begin
                r_res_vld <= 1'b1;
                r_res     <= w_biased[DATA_W-1:DATA_FRAC];
            end
            if (w_move) begin
                r_res_vld  <= 1'b0;
                r_busy     <= 1'b0;
                r_out_vld  <= 1'b1;
                r_out_data <= r_res;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.sample_out = r_out_data;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for biquad_equalizer_cascade_top: random and directed samples
// under changing coefficient sets, predicted in order. Needs beq_pkg, beq_in_if,
// beq_out_if and the block's RTL.
module testbench;
    import beq_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TARGET_ITEMS = 1550;
    localparam int DRAIN_CYCLES = 40;
    localparam int FORCED_HOLD  = 300;
    localparam int REG_FWD_OFS  = 0;
    localparam int REG_BWD_OFS  = 1;
    localparam int SAT_MAX      = 8388607;
    localparam int SAT_MIN      = -8388608;
    localparam int UNITY        = 1 << COEF_FRAC_BITS;
    localparam int COEF_MAX     = (1 << (COEF_W - 1)) - 1;
    localparam int COEF_MIN     = -(1 << (COEF_W - 1));
    localparam logic [CFG_W-1:0] BWD_MASK = {{(CFG_W - BWD_W){1'b0}}, {BWD_W{1'b1}}};

    typedef enum {SET_STABLE, SET_WILD, SET_EXTREME, SET_MIXED} t_coef_set;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       start;
    } t_audio_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    beq_in_if  in_bus ();
    beq_out_if out_bus ();

    biquad_equalizer_cascade_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    t_audio_item                pending_items [$];
    logic signed [SAMPLE_W-1:0] expected_samples [$];

    // predictor state: coefficient registers and per-band history
    logic [CFG_W-1:0] band_coefs [2*NUM_BANDS];
    int               x_hist [2*NUM_BANDS];
    int               y_hist [2*NUM_BANDS];
    logic [CFG_W-1:0] new_fwd [NUM_BANDS];
    logic [CFG_W-1:0] new_bwd [NUM_BANDS];

    int items_queued;
    int items_accepted;
    int result_count;
    int mismatch_count;
    int cycle_count;
    int send_gap;
    int rcv_gap;
    int rcv_hold;
    bit in_taken;
    bit hold_forced;
    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("tb: mismatch %0d: %s", mismatch_count, what);
    endtask

    function automatic longint coef_field(input logic [CFG_W-1:0] word, input int pos);
        logic signed [COEF_W-1:0] c;
        c = word[pos +: COEF_W];
        return longint'(c);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
            input logic signed [SAMPLE_W-1:0] s, input logic start);
        longint           acc;
        int               x, y, r, h, k;
        logic [CFG_W-1:0] fw, bw;
        x = int'(s) * (1 << DATA_FRAC);
        if (start) begin
            foreach (x_hist[i]) begin
                x_hist[i] = 0;
                y_hist[i] = 0;
            end
        end
        for (k = 0; k < NUM_BANDS; k++) begin
            h   = 2 * k;
            fw  = band_coefs[h + REG_FWD_OFS];
            bw  = band_coefs[h + REG_BWD_OFS];
            acc = coef_field(fw, 0) * x
                + coef_field(fw, COEF_W) * x_hist[h]
                + coef_field(fw, 2 * COEF_W) * x_hist[h + 1]
                - coef_field(bw, 0) * y_hist[h]
                - coef_field(bw, COEF_W) * y_hist[h + 1];
            acc = acc >>> COEF_FRAC_BITS;   // floor
            if (acc > SAT_MAX) y = SAT_MAX;
            else if (acc < SAT_MIN) y = SAT_MIN;
            else y = int'(acc);
            x_hist[h + 1] = x_hist[h];
            x_hist[h]     = x;
            y_hist[h + 1] = y_hist[h];
            y_hist[h]     = y;
            x = y;
        end
        r = x / (1 << DATA_FRAC);           // truncates toward zero
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[SAMPLE_W-1:0];
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [CFG_W-1:0] pack_fwd(input int b0, input int b1, input int b2);
        return {b2[COEF_W-1:0], b1[COEF_W-1:0], b0[COEF_W-1:0]};
    endfunction

    // bits above the register width get junk; the block must drop them
    function automatic logic [CFG_W-1:0] pack_bwd(input int a1, input int a2);
        return {COEF_W'($urandom), a2[COEF_W-1:0], a1[COEF_W-1:0]};
    endfunction

    function automatic int rand_coef(input int gain);
        return int'($urandom_range(0, 2 * gain * UNITY)) - gain * UNITY;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 2))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            case ($urandom_range(0, 4))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return '0;
                3:       return '1;
                default: return 16'sd1;
            endcase
        end
        if (roll < 60) return SAMPLE_W'($urandom);
        return SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
    endfunction

    task automatic queue_item(input logic signed [SAMPLE_W-1:0] s, input logic start);
        t_audio_item it;
        it.sample = s;
        it.start  = start;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    // mostly buffers that open with a start flag; some short, unflagged or restarted ones
    task automatic queue_buffers(input int count);
        int                         left, len, i;
        bit                         level;
        logic signed [SAMPLE_W-1:0] held;
        left = count;
        while (left > 0) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(8, 64);
            level = ($urandom_range(0, 4) == 0);
            held  = rand_sample();
            if (len > left) len = left;
            for (i = 0; i < len; i++) begin
                queue_item(level ? held : rand_sample(),
                           (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) == 0));
            end
            left -= len;
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (items_accepted != items_queued || expected_samples.size() != 0);
    endtask

    task automatic write_reg(input int idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx[CFG_IDX_W-1:0];
        i_cfg_data  <= value;
        band_coefs[idx] = ((idx % 2) == REG_BWD_OFS) ? (value & BWD_MASK) : value;
    endtask

    task automatic apply_bands();
        int k;
        for (k = 0; k < NUM_BANDS; k++) begin
            write_reg(2 * k + REG_FWD_OFS, new_fwd[k]);
            write_reg(2 * k + REG_BWD_OFS, new_bwd[k]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all_bands(input int b, input int a);
        int k;
        for (k = 0; k < NUM_BANDS; k++) begin
            new_fwd[k] = pack_fwd(b, b, b);
            new_bwd[k] = pack_bwd(a, a);
        end
    endtask

    task automatic choose_bands(input t_coef_set kind);
        int a1, a2, lim, k;
        for (k = 0; k < NUM_BANDS; k++) begin
            if (kind == SET_MIXED && $urandom_range(0, 1) == 0) begin
                new_fwd[k] = pack_fwd(UNITY, 0, 0);
                new_bwd[k] = pack_bwd(0, 0);
            end else if (kind == SET_STABLE || kind == SET_MIXED) begin
                // poles kept inside the stability triangle
                a2  = int'($urandom_range(0, 117964)) - 58982;
                lim = ((UNITY + a2) * 95) / 100;
                a1  = int'($urandom_range(0, 2 * lim)) - lim;
                new_fwd[k] = pack_fwd(rand_coef(2), rand_coef(2), rand_coef(2));
                new_bwd[k] = pack_bwd(a1, a2);
            end else if (kind == SET_WILD) begin
                new_fwd[k] = CFG_W'({$urandom, $urandom});
                new_bwd[k] = CFG_W'({$urandom, $urandom});
            end else begin
                new_fwd[k] = pack_fwd(pick_extreme(), pick_extreme(), pick_extreme());
                new_bwd[k] = pack_bwd(pick_extreme(), pick_extreme());
            end
        end
    endtask

    // sender: one transaction at a time from the pending queue
    always @(negedge i_clk) begin
        t_audio_item next_item;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            send_gap     <= 0;
        end else if (!in_bus.valid || in_taken) begin
            if (send_gap > 0) begin
                in_bus.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end else if (pending_items.size() > 0) begin
                next_item = pending_items.pop_front();
                in_bus.valid        <= 1'b1;
                in_bus.sample_in    <= next_item.sample;
                in_bus.buffer_start <= next_item.start;
                send_gap            <= send_idle_en ? pick_gap() : 0;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // receiver: short stalls, rare long holds, one forced hold while input keeps coming
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (rcv_hold > 0) begin
            out_bus.ready <= 1'b0;
            rcv_hold      <= rcv_hold - 1;
        end else if (!hold_forced && result_count >= 300
                     && items_queued - items_accepted > 8) begin
            out_bus.ready <= 1'b0;
            rcv_hold      <= FORCED_HOLD;
            hold_forced   <= 1'b1;
        end else if (recv_idle_en && $urandom_range(0, 2999) == 0) begin
            out_bus.ready <= 1'b0;
            rcv_hold      <= $urandom_range(100, 250);
        end else if (rcv_gap > 0) begin
            out_bus.ready <= 1'b0;
            rcv_gap       <= rcv_gap - 1;
        end else begin
            out_bus.ready <= 1'b1;
            rcv_gap       <= recv_idle_en ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_bus.valid && in_bus.ready;
            // check the result before queueing this edge's prediction
            if (out_bus.valid && out_bus.ready) begin
                result_count++;
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample_out %0d", out_bus.sample_out));
                end else begin
                    want = expected_samples.pop_front();
                    if (out_bus.sample_out !== want)
                        report_mismatch($sformatf("result %0d: sample_out %0d, want %0d",
                                                  result_count, out_bus.sample_out, want));
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                expected_samples.insert(expected_samples.size(),
                                        filter_sample(in_bus.sample_in, in_bus.buffer_start));
                items_accepted++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int        k, phase_items;
        bit        calm;
        t_coef_set kind;
        i_rst_n             = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.sample_in    = '0;
        in_bus.buffer_start = 1'b0;
        out_bus.ready       = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = '0;
        i_cfg_data          = '0;
        for (k = 0; k < NUM_BANDS; k++) begin
            band_coefs[2 * k + REG_FWD_OFS] = FWD_RESET;
            band_coefs[2 * k + REG_BWD_OFS] = BWD_RESET;
        end
        foreach (x_hist[i]) begin
            x_hist[i] = 0;
            y_hist[i] = 0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients are identity: extremes pass straight through
        @(posedge i_clk);
        queue_item(16'sh7FFF, 1'b1);
        queue_item(16'sh8000, 1'b0);
        queue_item('0, 1'b0);
        queue_item('1, 1'b0);
        queue_item(16'sd1, 1'b1);
        wait_drained();

        // gain just over a quarter: floor inside the section, truncation at the output
        for (k = 0; k < NUM_BANDS; k++) begin
            new_fwd[k] = pack_fwd(UNITY, 0, 0);
            new_bwd[k] = pack_bwd(0, 0);
        end
        new_fwd[0] = pack_fwd(UNITY / 4 + 1, 0, 0);
        apply_bands();
        @(posedge i_clk);
        queue_item(-16'sd1, 1'b1);
        queue_item(-16'sd3, 1'b0);
        queue_item(16'sd3, 1'b0);
        queue_item(16'sh8000, 1'b0);
        queue_item(16'sh7FFF, 1'b0);
        wait_drained();

        // largest positive coefficients everywhere: saturation in every section
        set_all_bands(COEF_MAX, COEF_MAX);
        apply_bands();
        @(posedge i_clk);
        queue_item(16'sh7FFF, 1'b1);
        queue_item(16'sh8000, 1'b0);
        queue_item(16'sh7FFF, 1'b0);
        queue_item(16'sd1, 1'b0);
        wait_drained();

        set_all_bands(COEF_MIN, COEF_MIN);
        apply_bands();
        @(posedge i_clk);
        queue_item(16'sh8000, 1'b1);
        queue_item(16'sh7FFF, 1'b0);
        queue_item('1, 1'b0);
        queue_item('0, 1'b0);
        wait_drained();

        set_all_bands(0, 0);
        apply_bands();
        @(posedge i_clk);
        queue_item(16'sd12345, 1'b1);
        queue_item(16'sh8000, 1'b0);
        wait_drained();

        while (items_queued < TARGET_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: kind = SET_STABLE;
                10, 11, 12:                   kind = SET_WILD;
                13, 14:                       kind = SET_EXTREME;
                default:                      kind = SET_MIXED;
            endcase
            choose_bands(kind);
            apply_bands();
            @(posedge i_clk);
            calm         = ($urandom_range(0, 3) == 0);
            send_idle_en = !calm;
            recv_idle_en = !calm;
            phase_items  = $urandom_range(60, 180);
            queue_buffers(phase_items / 2);
            // sender holds back mid-phase until every result is in
            wait_drained();
            @(posedge i_clk);
            queue_buffers(phase_items - phase_items / 2);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
src/beq_pkg.sv
src/beq_in_if.sv
src/beq_out_if.sv
src/beq_cell.sv
src/biquad_equalizer_cascade_top.sv
sim/testbench.sv
